// ===== src/cpia_pkg.sv =====
package cpia_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 30;

  // accumulator saturation bound, +-(2^62 - 1)
  localparam logic signed [63:0] SUM_LIMIT = 64'sh3FFF_FFFF_FFFF_FFFF;

  // rounded atan(2^-i) in Q30 radians
  localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
    30'd843314857, 30'd497837829, 30'd263043836, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2
  };

  // request from the polygon sequencer to the edge engine
  typedef struct packed {
    logic               start;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
  } edge_req_t;

  // edge engine answer
  typedef struct packed {
    logic               done;
    logic signed [63:0] contrib;
  } edge_rsp_t;

  typedef enum logic [2:0] {
    TS_IDLE, TS_EDGE, TS_POST, TS_CLOSE, TS_OUT
  } top_state_t;

  typedef enum logic [4:0] {
    ES_IDLE, ES_SCALE, ES_CR1, ES_CR2, ES_CR3, ES_ZERO, ES_L1, ES_L2,
    ES_SQRT, ES_SQEND, ES_AD1, ES_AD2, ES_AD3, ES_DIV, ES_DIVEND,
    ES_BD1, ES_BD2, ES_BD3, ES_HDIV, ES_R2, ES_R2B, ES_W1, ES_W2,
    ES_PICK, ES_ANG0, ES_NORM, ES_ROT, ES_ANGEND, ES_SEC1, ES_SEC2,
    ES_SEC3, ES_TRI
  } edge_state_t;

  typedef enum logic [1:0] {
    DT_SA, DT_SB, DT_H
  } div_tag_t;

endpackage

// ===== src/cpia_ifs.sv =====
interface cpia_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic               last_vertex;
  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface cpia_area_if;
  logic        valid;
  logic        ready;
  logic [61:0] overlap_area;
  modport source (output valid, overlap_area, input ready);
  modport sink   (input valid, overlap_area, output ready);
endinterface

interface cpia_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] radius;
  modport source (output valid, radius, input ready);
  modport sink   (input valid, radius, output ready);
endinterface

// ===== src/circle_polygon_intersection_area_unit.sv =====
// Circle / polygon overlap area. Vertices of a simple polygon arrive one per
// transfer on vtx in signed Q15.16; a transfer with last_vertex high closes the
// polygon and, once the closing edge is done, one transfer on area carries the
// absolute overlap with the circle of radius cfg.radius centred at the origin
// (16 fraction bits). Each edge runs on a single edge engine built around one
// shared 33x33 multiplier, a radix-2 divider (three quotients per edge), a
// bit-pair square root (up to two roots per edge) and a 30-step CORDIC (two
// angles per sector, at most two sectors). An edge that passes through the
// origin or is collinear with it ends once its cross product is known. A vertex
// after the first holds vtx off while its edge runs, a closing vertex also while
// the closing edge runs and until the output register is free. The result sits
// in an output register, so the next polygon may start while it waits to be
// taken. The radius must be written through cfg only while no polygon is in
// flight; the block itself does not enforce this.
module circle_polygon_intersection_area_unit (
  input logic        clk,
  input logic        rst,
  cpia_vtx_if.sink   vtx,
  cpia_area_if.source area,
  cpia_cfg_if.sink   cfg
);
  import cpia_pkg::*;

  top_state_t state, state_next;

  logic [30:0]        radius;
  logic signed [31:0] first_x, first_y, prev_x, prev_y, cur_x, cur_y;
  logic               cur_last;
  logic               have_vertex;
  logic signed [63:0] area_sum;
  logic               out_valid;
  logic [61:0]        out_area;

  edge_req_t          req;
  edge_rsp_t          rsp;

  logic               vtx_xfer;
  logic               out_load;
  logic signed [64:0] sum_wide;
  logic signed [63:0] sum_sat;
  logic [63:0]        sum_mag;

  cpia_edge u_edge (
    .clk    (clk),
    .rst    (rst),
    .radius (radius),
    .req    (req),
    .rsp    (rsp)
  );

  assign cfg.ready = 1'b1;
  assign vtx.ready = (state == TS_IDLE);
  assign vtx_xfer  = vtx.valid && vtx.ready;
  assign area.valid        = out_valid;
  assign area.overlap_area = out_area;

  // saturating accumulate
  always_comb begin
    sum_wide = 65'(area_sum) + 65'(rsp.contrib);
    if (sum_wide > 65'(SUM_LIMIT)) sum_sat = SUM_LIMIT;
    else if (sum_wide < -65'(SUM_LIMIT)) sum_sat = -SUM_LIMIT;
    else sum_sat = 64'(sum_wide);
    sum_mag = area_sum[63] ? 64'(-area_sum) : 64'(area_sum);
  end

  // polygon sequencer
  always_comb begin
    state_next = state;
    req = '0;
    out_load = 1'b0;
    unique case (state)
      TS_IDLE: begin
        if (vtx_xfer) begin
          if (have_vertex) begin
            req.start = 1'b1;
            req.ax = prev_x; req.ay = prev_y;
            req.bx = vtx.vertex_x; req.by = vtx.vertex_y;
            state_next = TS_EDGE;
          end else begin
            state_next = TS_POST;
          end
        end
      end
      TS_EDGE:  if (rsp.done) state_next = TS_POST;
      TS_POST: begin
        if (cur_last) begin
          req.start = 1'b1;
          req.ax = cur_x; req.ay = cur_y;
          req.bx = first_x; req.by = first_y;
          state_next = TS_CLOSE;
        end else begin
          state_next = TS_IDLE;
        end
      end
      TS_CLOSE: if (rsp.done) state_next = TS_OUT;
      TS_OUT: begin
        if (!out_valid || area.ready) begin
          out_load = 1'b1;
          state_next = TS_IDLE;
        end
      end
      default:  state_next = TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= TS_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= '0;
      have_vertex <= 1'b0;
      area_sum    <= '0;
      out_valid   <= 1'b0;
      first_x <= '0; first_y <= '0; prev_x <= '0; prev_y <= '0;
    end else begin
      if (cfg.valid && cfg.ready) radius <= cfg.radius;

      // vertex capture
      if (vtx_xfer) begin
        cur_x    <= vtx.vertex_x;
        cur_y    <= vtx.vertex_y;
        cur_last <= vtx.last_vertex;
        if (!have_vertex) begin
          first_x     <= vtx.vertex_x;
          first_y     <= vtx.vertex_y;
          have_vertex <= 1'b1;
        end
      end
      if (state == TS_POST) begin
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
      if (rsp.done) area_sum <= sum_sat;

      // result register
      if (out_load) begin
        out_valid <= 1'b1;
        out_area  <= sum_mag[61:0];
        first_x <= '0; first_y <= '0; prev_x <= '0; prev_y <= '0;
        area_sum    <= '0;
        have_vertex <= 1'b0;
      end else if (area.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // edge results only come back while the sequencer waits for them
  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == TS_EDGE || state == TS_CLOSE))
    else $error("edge result outside an edge wait");

  a_sum_in_range: assert property (@(posedge clk) disable iff (rst)
    area_sum <= SUM_LIMIT && area_sum >= -SUM_LIMIT)
    else $error("area accumulator beyond saturation bound");

  a_first_kept: assert property (@(posedge clk) disable iff (rst)
    (vtx_xfer && !have_vertex) |=> have_vertex)
    else $error("first vertex not recorded");

  a_cleared_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(area.valid) |-> !have_vertex)
    else $error("polygon state not cleared with the result");

endmodule

// ===== src/cpia_edge.sv =====
module cpia_edge (
  input  logic                clk,
  input  logic                rst,
  input  logic [30:0]         radius,
  input  cpia_pkg::edge_req_t req,
  output cpia_pkg::edge_rsp_t rsp
);
  import cpia_pkg::*;

  edge_state_t state, state_next;

  // latched edge
  logic signed [31:0] in_ax, in_ay, in_bx, in_by;
  logic [30:0]        in_r;

  // scaled geometry
  logic [1:0]         sh;
  logic signed [29:0] a_x, a_y, b_x, b_y;
  logic [28:0]        rr;
  logic signed [30:0] d_x, d_y;
  logic signed [61:0] cr;
  logic [30:0]        len;
  logic signed [31:0] sa, sb;
  logic [31:0]        h;
  logic [57:0]        r2;
  logic [28:0]        w;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod, acc;

  // divider
  logic [63:0]        div_num;
  logic [32:0]        div_rem;
  logic [5:0]         div_cnt;
  logic               div_neg;
  div_tag_t           div_tag;

  // square root
  logic [63:0]        sq_v, sq_res, sq_bit;
  logic               sq_is_w;

  // cordic
  logic signed [35:0] cx, cy;
  logic signed [33:0] cz, z1;
  logic [4:0]         ci;
  logic               ang_second;
  logic signed [34:0] dz;

  // sector list and sums
  logic               need1, need2, tri_en;
  logic signed [31:0] s1a, s1b, s2a, s2b, t1, t2;
  logic [31:0]        tri_len;
  logic [63:0]        sec, tot;

  // response
  logic               done_r;
  logic signed [63:0] contrib_v;

  // helpers
  logic [31:0]        ma, mb, mc, md, m_or;
  logic [1:0]         sh_calc;
  logic signed [65:0] dsum;
  logic [65:0]        dmag;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic [63:0]        sq_t;
  logic               sq_ge;
  logic signed [35:0] xs, ys;
  logic signed [33:0] atan_v;
  logic signed [31:0] t_cur, q_signed, w_s, negw, il, ir;
  logic [61:0]        cr_mag;
  logic [5:0]         kk;
  logic [63:0]        out_v;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // block scaling shift
  always_comb begin
    ma = abs32(in_ax);
    mb = abs32(in_ay);
    mc = abs32(in_bx);
    md = abs32(in_by);
    m_or = ma | mb | mc | md | {1'b0, in_r};
    if (m_or[31]) sh_calc = 2'd3;
    else if (m_or[30]) sh_calc = 2'd2;
    else if (m_or[29]) sh_calc = 2'd1;
    else sh_calc = 2'd0;
  end

  // datapath helpers
  always_comb begin
    dsum     = acc + prod;
    dmag     = dsum[65] ? 66'(-dsum) : 66'(dsum);
    rem_sh   = {div_rem[31:0], div_num[63]};
    rem_ge   = rem_sh >= {2'b00, len};
    sq_t     = sq_res + sq_bit;
    sq_ge    = sq_v >= sq_t;
    xs       = cx >>> ci;
    ys       = cy >>> ci;
    atan_v   = $signed({4'b0000, ATAN_Q30[ci]});
    t_cur    = ang_second ? t2 : t1;
    q_signed = div_neg ? -$signed(div_num[31:0]) : $signed(div_num[31:0]);
    w_s      = $signed({3'b000, w});
    negw     = -w_s;
    il       = (sa > negw) ? sa : negw;
    ir       = (sb < w_s) ? sb : w_s;
    cr_mag   = cr[61] ? 62'(-cr) : 62'(cr);
    kk       = 6'(FRAC_BITS + 1) - {3'b000, sh, 1'b0};
    out_v    = (tot + (64'd1 << (kk - 6'd1))) >> kk;
  end

  // sequencer and multiplier operand select
  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ES_IDLE:   if (req.start) state_next = ES_SCALE;
      ES_SCALE:  state_next = ES_CR1;
      ES_CR1: begin
        mul_a = 33'(a_x); mul_b = 33'(b_y);
        state_next = ES_CR2;
      end
      ES_CR2: begin
        mul_a = 33'(a_y); mul_b = 33'(b_x);
        state_next = ES_CR3;
      end
      ES_CR3:    state_next = ES_ZERO;
      ES_ZERO: begin
        mul_a = 33'(d_x); mul_b = 33'(d_x);
        state_next = (cr == '0) ? ES_IDLE : ES_L1;
      end
      ES_L1: begin
        mul_a = 33'(d_y); mul_b = 33'(d_y);
        state_next = ES_L2;
      end
      ES_L2:     state_next = ES_SQRT;
      ES_SQRT:   if (sq_bit[0]) state_next = ES_SQEND;
      ES_SQEND:  state_next = sq_is_w ? ES_W2 : ES_AD1;
      ES_AD1: begin
        mul_a = 33'(a_x); mul_b = 33'(d_x);
        state_next = ES_AD2;
      end
      ES_AD2: begin
        mul_a = 33'(a_y); mul_b = 33'(d_y);
        state_next = ES_AD3;
      end
      ES_AD3:    state_next = ES_DIV;
      ES_DIV:    if (div_cnt == 6'd63) state_next = ES_DIVEND;
      ES_DIVEND: begin
        unique case (div_tag)
          DT_SA:   state_next = ES_BD1;
          DT_SB:   state_next = ES_HDIV;
          default: state_next = ES_R2;
        endcase
      end
      ES_BD1: begin
        mul_a = 33'(b_x); mul_b = 33'(d_x);
        state_next = ES_BD2;
      end
      ES_BD2: begin
        mul_a = 33'(b_y); mul_b = 33'(d_y);
        state_next = ES_BD3;
      end
      ES_BD3:    state_next = ES_DIV;
      ES_HDIV:   state_next = ES_DIV;
      ES_R2: begin
        mul_a = $signed({4'b0000, rr}); mul_b = $signed({4'b0000, rr});
        state_next = ES_R2B;
      end
      ES_R2B: begin
        mul_a = $signed({1'b0, h}); mul_b = $signed({1'b0, h});
        state_next = (h >= 32'(rr)) ? ES_PICK : ES_W1;
      end
      ES_W1:     state_next = ES_SQRT;
      ES_W2:     state_next = ES_PICK;
      ES_PICK:   state_next = (need1 || need2) ? ES_ANG0 : ES_TRI;
      ES_ANG0:   state_next = (t_cur == '0) ? ES_ANGEND : ES_NORM;
      ES_NORM: begin
        if (!(cx < 36'sd1073741824 && cy < 36'sd1073741824
              && cy > -36'sd1073741824)) state_next = ES_ROT;
      end
      ES_ROT:    if (ci == 5'(CORDIC_STEPS - 1)) state_next = ES_ANGEND;
      ES_ANGEND: state_next = ang_second ? ES_SEC1 : ES_ANG0;
      ES_SEC1: begin
        mul_a = $signed({7'b0, r2[57:32]}); mul_b = $signed({1'b0, dz[31:0]});
        state_next = (dz[34] || dz == '0) ? ES_PICK : ES_SEC2;
      end
      ES_SEC2: begin
        mul_a = $signed({1'b0, r2[31:0]}); mul_b = $signed({1'b0, dz[31:0]});
        state_next = ES_SEC3;
      end
      ES_SEC3:   state_next = ES_PICK;
      ES_TRI: begin
        mul_a = $signed({1'b0, h}); mul_b = $signed({1'b0, tri_len});
        state_next = ES_IDLE;
      end
      default:   state_next = ES_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ES_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      done_r <= 1'b0;
      need1 <= 1'b0;
      need2 <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state)
        ES_IDLE: begin
          if (req.start) begin
            in_ax <= req.ax; in_ay <= req.ay; in_bx <= req.bx; in_by <= req.by;
            in_r  <= radius;
          end
        end
        ES_SCALE: begin
          sh  <= sh_calc;
          a_x <= 30'(in_ax >>> sh_calc);
          a_y <= 30'(in_ay >>> sh_calc);
          b_x <= 30'(in_bx >>> sh_calc);
          b_y <= 30'(in_by >>> sh_calc);
          rr  <= 29'(in_r >> sh_calc);
        end
        ES_CR2:  acc <= prod;
        ES_CR3: begin
          cr  <= 62'(acc - prod);
          d_x <= 31'(b_x) - 31'(a_x);
          d_y <= 31'(b_y) - 31'(a_y);
        end
        ES_ZERO: begin
          // collinear or degenerate edge adds nothing
          if (cr == '0) done_r <= 1'b1;
        end
        ES_L1:   acc <= prod;
        ES_L2: begin
          sq_v    <= 64'(dsum);
          sq_res  <= '0;
          sq_bit  <= 64'd1 << 62;
          sq_is_w <= 1'b0;
        end
        ES_SQRT: begin
          if (sq_ge) begin
            sq_v   <= sq_v - sq_t;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
        ES_SQEND: begin
          if (sq_is_w) w <= 29'(sq_res);
          else len <= 31'(sq_res);
        end
        ES_AD2, ES_BD2: acc <= prod;
        ES_AD3, ES_BD3: begin
          div_num <= 64'(dmag);
          div_neg <= dsum[65];
          div_rem <= '0;
          div_cnt <= '0;
          div_tag <= (state == ES_AD3) ? DT_SA : DT_SB;
        end
        ES_HDIV: begin
          div_num <= 64'(cr_mag) + 64'(len >> 1);
          div_neg <= 1'b0;
          div_rem <= '0;
          div_cnt <= '0;
          div_tag <= DT_H;
        end
        ES_DIV: begin
          if (rem_ge) begin
            div_rem <= rem_sh - {2'b00, len};
            div_num <= {div_num[62:0], 1'b1};
          end else begin
            div_rem <= rem_sh;
            div_num <= {div_num[62:0], 1'b0};
          end
          div_cnt <= div_cnt + 6'd1;
        end
        ES_DIVEND: begin
          unique case (div_tag)
            DT_SA:   sa <= q_signed;
            DT_SB:   sb <= q_signed;
            default: h  <= div_num[31:0];
          endcase
        end
        ES_R2B: begin
          r2  <= 58'(prod);
          sec <= '0;
          // edge line misses the circle: one sector over the whole edge
          need1  <= 1'b1;
          need2  <= 1'b0;
          tri_en <= 1'b0;
          s1a    <= sa;
          s1b    <= sb;
        end
        ES_W1: begin
          sq_v    <= 64'(r2) - 64'(prod);
          sq_res  <= '0;
          sq_bit  <= 64'd1 << 62;
          sq_is_w <= 1'b1;
        end
        ES_W2: begin
          need1   <= sa < negw;
          s1a     <= sa;
          s1b     <= (sb < negw) ? sb : negw;
          need2   <= sb > w_s;
          s2a     <= (sa > w_s) ? sa : w_s;
          s2b     <= sb;
          tri_en  <= ir > il;
          tri_len <= 32'(ir - il);
        end
        ES_PICK: begin
          ang_second <= 1'b0;
          if (need1) begin
            need1 <= 1'b0; t1 <= s1a; t2 <= s1b;
          end else if (need2) begin
            need2 <= 1'b0; t1 <= s2a; t2 <= s2b;
          end
        end
        ES_ANG0: begin
          cx <= $signed({4'b0000, h});
          cy <= 36'(t_cur);
          cz <= '0;
          ci <= '0;
        end
        ES_NORM: begin
          if (cx < 36'sd1073741824 && cy < 36'sd1073741824
              && cy > -36'sd1073741824) begin
            cx <= cx <<< 1;
            cy <= cy <<< 1;
          end
        end
        ES_ROT: begin
          if (cy > 36'sd0) begin
            cx <= cx + ys; cy <= cy - xs; cz <= cz + atan_v;
          end else begin
            cx <= cx - ys; cy <= cy + xs; cz <= cz - atan_v;
          end
          ci <= ci + 5'd1;
        end
        ES_ANGEND: begin
          if (ang_second) dz <= 35'(cz) - 35'(z1);
          else begin
            z1 <= cz;
            ang_second <= 1'b1;
          end
        end
        ES_SEC2: acc <= prod;
        ES_SEC3: sec <= sec + (64'(acc) << 2) + ((64'(prod) + (64'd1 << 29)) >> 30);
        ES_TRI: begin
          // closing step of the edge: sum, round, sign
          done_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // total and rounding, combinational on the registered product of the strip term
  always_comb begin
    tot = tri_en ? sec + 64'(prod) : sec;
  end

  assign contrib_v = (cr == '0) ? 64'sd0 : (cr[61] ? -$signed(out_v) : $signed(out_v));
  assign rsp       = {done_r, contrib_v};

endmodule

// ===== sim/cpia_area_checker.sv =====
`timescale 1ns / 100ps

module cpia_area_checker (
  input  logic   clk,
  input  logic   rst,
  cpia_vtx_if    vtx,
  cpia_area_if   area,
  cpia_cfg_if    cfg,
  output int     fail_count,
  output int     areas_pending
);
  import cpia_pkg::*;

  // mirrored block state
  logic [30:0]    radius_q;
  longint         first_x, first_y, prev_x, prev_y, area_acc;
  logic           have_first;
  logic [61:0]    area_queue [$];

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // cordic vectoring, atan2(y, x) in q30 radians
  function automatic longint cordic_angle(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    if (y == 0) return 0;
    while (abs64(x) < (64'd1 << 30) && abs64(y) < (64'd1 << 30)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_Q30[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_Q30[i]);
      end
    end
    return z;
  endfunction

  // twice the sector area between two along-line positions
  function automatic longint unsigned sector_area(longint unsigned r2, longint h,
                                                  longint t1, longint t2);
    longint dz;
    longint unsigned d;
    dz = cordic_angle(h, t2) - cordic_angle(h, t1);
    if (dz <= 0) return 0;
    d = dz;
    return (((r2 >> 32) * d) << 2) + (((r2 & 64'hFFFF_FFFF) * d + (64'd1 << 29)) >> 30);
  endfunction

  // signed overlap of triangle (origin, a, b) with the circle
  function automatic longint edge_area(longint ax, longint ay, longint bx, longint by);
    longint unsigned m, r2, strip, sec, tot, res, uc;
    int s, k;
    longint cr, dx, dy, len, sa, sb, h, rr, w, il, ir;
    m = radius_q;
    strip = 0;
    sec = 0;
    if (abs64(ax) > m) m = abs64(ax);
    if (abs64(ay) > m) m = abs64(ay);
    if (abs64(bx) > m) m = abs64(bx);
    if (abs64(by) > m) m = abs64(by);
    s = 0;
    while ((m >> s) >= (64'd1 << 29)) s++;
    ax = ax >>> s; ay = ay >>> s; bx = bx >>> s; by = by >>> s;
    rr = longint'(radius_q) >> s;
    cr = ax * by - ay * bx;
    if (cr == 0) return 0;
    dx = bx - ax;
    dy = by - ay;
    len = int_sqrt(dx * dx + dy * dy);
    sa = (ax * dx + ay * dy) / len;
    sb = (bx * dx + by * dy) / len;
    uc = abs64(cr);
    h = longint'((uc + (longint'(len) >> 1)) / longint'(len));
    r2 = rr * rr;
    if (h >= rr) begin
      sec = sector_area(r2, h, sa, sb);
    end else begin
      w = int_sqrt(rr * rr - h * h);
      il = sa > -w ? sa : -w;
      ir = sb < w ? sb : w;
      if (sa < -w) sec = sec + sector_area(r2, h, sa, sb < -w ? sb : -w);
      if (sb > w) sec = sec + sector_area(r2, h, sa > w ? sa : w, sb);
      if (ir > il) strip = h * (ir - il);
    end
    tot = sec + strip;
    k = FRAC_BITS + 1 - 2 * s;
    res = (tot + (64'd1 << (k - 1))) >> k;
    return cr > 0 ? longint'(res) : -longint'(res);
  endfunction

  function automatic longint saturate_add(longint acc, longint c);
    longint t;
    t = acc + c;
    if (t > SUM_LIMIT) t = SUM_LIMIT;
    if (t < -SUM_LIMIT) t = -SUM_LIMIT;
    return t;
  endfunction

  assign areas_pending = area_queue.size();

  // watch transfers, predict and compare
  always @(posedge clk) begin
    longint cx, cy;
    logic [61:0] want;
    if (rst) begin
      radius_q   <= '0;
      first_x = 0; first_y = 0; prev_x = 0; prev_y = 0; area_acc = 0;
      have_first = 1'b0;
      fail_count <= 0;
    end else begin
      if (area.valid && area.ready) begin
        if (area_queue.size() == 0) begin
          $display("%0t: unexpected area transfer, actual %0d", $time, area.overlap_area);
          fail_count <= fail_count + 1;
        end else begin
          want = area_queue.pop_front();
          if (want !== area.overlap_area) begin
            $display("%0t: overlap_area mismatch, expected %0d actual %0d",
                     $time, want, area.overlap_area);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg.valid && cfg.ready) radius_q <= cfg.radius;
      if (vtx.valid && vtx.ready) begin
        cx = longint'(vtx.vertex_x);
        cy = longint'(vtx.vertex_y);
        if (!have_first) begin
          first_x = cx; first_y = cy;
          have_first = 1'b1;
        end else begin
          area_acc = saturate_add(area_acc, edge_area(prev_x, prev_y, cx, cy));
        end
        prev_x = cx; prev_y = cy;
        if (vtx.last_vertex) begin
          area_acc = saturate_add(area_acc, edge_area(cx, cy, first_x, first_y));
          area_queue.push_back(62'(abs64(area_acc)));
          first_x = 0; first_y = 0; prev_x = 0; prev_y = 0; area_acc = 0;
          have_first = 1'b0;
        end
      end
    end
  end

endmodule

// ===== sim/circle_polygon_intersection_area_unit_tb.sv =====
`timescale 1ns / 100ps

module circle_polygon_intersection_area_unit_tb;

  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam int     DRAIN_CYCLES = 1500;

  logic   clk;
  logic   rst;
  int     fail_count;
  int     areas_pending;
  longint cycles = 0;
  logic [30:0] cur_radius;

  cpia_vtx_if  vtx ();
  cpia_area_if area ();
  cpia_cfg_if  cfg ();

  circle_polygon_intersection_area_unit u_dut (
    .clk  (clk),
    .rst  (rst),
    .vtx  (vtx),
    .area (area),
    .cfg  (cfg)
  );

  cpia_area_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .vtx           (vtx),
    .area          (area),
    .cfg           (cfg),
    .fail_count    (fail_count),
    .areas_pending (areas_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(20, 4);
    return $urandom_range(300, 50);
  endfunction

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("circle_polygon_intersection_area_unit_tb: FAIL");
      $finish;
    end
  end

  // result side back-pressure, with stall-free stretches
  initial begin
    int n;
    area.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = $urandom_range(99) < 20 ? $urandom_range(400, 50) : $urandom_range(8, 1);
      area.ready <= 1'b1;
      repeat (n) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        area.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      vtx.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    vtx.valid       <= 1'b1;
    vtx.vertex_x    <= x;
    vtx.vertex_y    <= y;
    vtx.last_vertex <= last;
    @(posedge clk);
    while (!vtx.ready) @(posedge clk);
  endtask

  // radius write while the block is idle
  task automatic set_radius(input logic [30:0] r);
    vtx.valid <= 1'b0;
    while (areas_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg.valid  <= 1'b1;
    cfg.radius <= r;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    cur_radius = r;
  endtask

  function automatic logic signed [31:0] rand_coord();
    longint span;
    longint unsigned raw;
    longint v;
    if ($urandom_range(99) < 15) return $urandom;
    span = 2 * longint'(cur_radius) + 256;
    raw  = {$urandom, $urandom};
    v    = longint'(raw % longint'(2 * span + 1)) - span;
    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v[31:0];
  endfunction

  task automatic random_polygons(input int count);
    int n;
    logic signed [31:0] x, y;
    while (count > 0) begin
      n = $urandom_range(99) < 80 ? $urandom_range(6, 3) : $urandom_range(10, 1);
      for (int i = 0; i < n; i++) begin
        if (i == 0 || $urandom_range(99) >= 5) begin
          x = rand_coord();
          y = rand_coord();
        end
        send_vertex(x, y, i == n - 1);
      end
      count -= n;
    end
  endtask

  // stimulus
  initial begin
    logic [30:0] radii [6];
    rst        = 1'b1;
    vtx.valid  = 1'b0;
    vtx.vertex_x = '0;
    vtx.vertex_y = '0;
    vtx.last_vertex = 1'b0;
    cfg.valid  = 1'b0;
    cfg.radius = '0;
    cur_radius = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: radius 10.0
    set_radius(31'd655360);
    // square around the origin, larger than the circle
    send_vertex(-32'sd1310720, -32'sd1310720, 1'b0);
    send_vertex( 32'sd1310720, -32'sd1310720, 1'b0);
    send_vertex( 32'sd1310720,  32'sd1310720, 1'b0);
    send_vertex(-32'sd1310720,  32'sd1310720, 1'b1);
    // small triangle fully inside, clockwise
    send_vertex(32'sd65536, 32'sd0, 1'b0);
    send_vertex(32'sd0, 32'sd65536, 1'b0);
    send_vertex(32'sd65536, 32'sd65536, 1'b1);
    // single vertex polygon
    send_vertex(32'sd12345, -32'sd777, 1'b1);
    // zero-length edge, collinear and through-origin edges
    send_vertex(32'sd65536, 32'sd65536, 1'b0);
    send_vertex(32'sd65536, 32'sd65536, 1'b0);
    send_vertex(32'sd131072, 32'sd131072, 1'b0);
    send_vertex(-32'sd131072, -32'sd131072, 1'b0);
    send_vertex(32'sd0, 32'sd196608, 1'b1);
    // coordinate extremes, far outside
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    send_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    // edge crossing the circle twice
    send_vertex(-32'sd1310720, 32'sd65536, 1'b0);
    send_vertex(32'sd1310720, 32'sd65536, 1'b0);
    send_vertex(32'sd0, -32'sd131072, 1'b1);

    // zero radius, then maximum radius with extreme square
    set_radius(31'd0);
    send_vertex(32'sd65536, 32'sd0, 1'b0);
    send_vertex(32'sd0, 32'sd65536, 1'b0);
    send_vertex(-32'sd65536, -32'sd65536, 1'b1);
    set_radius(31'h7FFF_FFFF);
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    send_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);

    // random phases over several radii
    radii[0] = 31'd655360;
    radii[1] = 31'd1;
    radii[2] = 31'h7FFF_FFFF;
    radii[3] = 31'd0;
    radii[4] = 31'($urandom);
    radii[5] = 31'($urandom_range(31'h00FF_FFFF, 31'd4096));
    foreach (radii[i]) begin
      set_radius(radii[i]);
      random_polygons(i == 3 ? 60 : 340);
    end

    // drain and verdict
    vtx.valid <= 1'b0;
    while (areas_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("circle_polygon_intersection_area_unit_tb: PASS");
    end else begin
      $display("circle_polygon_intersection_area_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== circle_polygon_intersection_area_unit.f =====
src/cpia_pkg.sv
src/cpia_ifs.sv
src/cpia_edge.sv
src/circle_polygon_intersection_area_unit.sv
sim/cpia_area_checker.sv
sim/circle_polygon_intersection_area_unit_tb.sv
